>>> rtl/sphere_obb_closest_point_test_defines.svh
// Assertion macros for the checker file of the sphere to box test.
`ifndef SPHERE_OBB_CLOSEST_POINT_TEST_DEFINES_SVH
`define SPHERE_OBB_CLOSEST_POINT_TEST_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define SOBB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SOBB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sobb_pkg.sv
// Shared widths, register codes, configuration struct and lane helpers.
package sobb_pkg;

  localparam int COORD_WIDTH_DEFAULT = 16;

  localparam int REG_W      = 48;
  localparam int LANE_W     = 16;
  localparam int AXIS_FRAC  = 14;
  localparam int ROUND_HALF = 8192;
  localparam int RADIUS_W   = 15;
  localparam int RSQ_W      = 2 * RADIUS_W;
  localparam int DIST_W     = 34;
  localparam int T_W        = LANE_W + 1;
  localparam int TPW        = T_W + LANE_W;
  localparam int QW         = TPW + 3;
  localparam int CL_W       = QW - AXIS_FRAC;
  localparam int DIFF_CLAMP = 131072;
  localparam int MAG_W      = 18;
  localparam int SQ_W       = 2 * MAG_W - 1;
  localparam int SUM_W      = SQ_W + 1;
  localparam int CFG_IDX_W  = 3;

  localparam logic [REG_W-1:0] AXIS_U_RESET       = 48'd16384;
  localparam logic [REG_W-1:0] AXIS_V_RESET       = 48'd1073741824;
  localparam logic [REG_W-1:0] AXIS_W_RESET       = 48'd70368744177664;
  localparam logic [REG_W-1:0] BOX_CENTER_RESET   = 48'd0;
  localparam logic [REG_W-1:0] HALF_EXTENTS_RESET = 48'd1099528405248;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_U       = 3'd0,
    REG_AXIS_V       = 3'd1,
    REG_AXIS_W       = 3'd2,
    REG_BOX_CENTER   = 3'd3,
    REG_HALF_EXTENTS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] axis_u;
    logic [REG_W-1:0] axis_v;
    logic [REG_W-1:0] axis_w;
    logic [REG_W-1:0] box_center;
    logic [REG_W-1:0] half_extents;
  } cfg_t;

  function automatic logic signed [LANE_W-1:0] axis_comp(cfg_t c, int i, int k);
    logic [REG_W-1:0] r;
    case (i)
      0:       r = c.axis_u;
      1:       r = c.axis_v;
      default: r = c.axis_w;
    endcase
    return $signed(r[LANE_W*k +: LANE_W]);
  endfunction

  function automatic logic signed [LANE_W-1:0] center_comp(cfg_t c, int k);
    return $signed(c.box_center[LANE_W*k +: LANE_W]);
  endfunction

  function automatic logic [LANE_W-1:0] half_comp(cfg_t c, int k);
    return c.half_extents[LANE_W*k +: LANE_W];
  endfunction

endpackage

>>> rtl/sobb_cfg.sv
// Configuration register file for the box axes, centre and half sizes.
module sobb_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sobb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sobb_pkg::REG_W-1:0]      cfg_data,
  output sobb_pkg::cfg_t                  cfg
);
  import sobb_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_u       <= AXIS_U_RESET;
      cfg.axis_v       <= AXIS_V_RESET;
      cfg.axis_w       <= AXIS_W_RESET;
      cfg.box_center   <= BOX_CENTER_RESET;
      cfg.half_extents <= HALF_EXTENTS_RESET;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_AXIS_U:       cfg.axis_u       <= cfg_data;
        REG_AXIS_V:       cfg.axis_v       <= cfg_data;
        REG_AXIS_W:       cfg.axis_w       <= cfg_data;
        REG_BOX_CENTER:   cfg.box_center   <= cfg_data;
        REG_HALF_EXTENTS: cfg.half_extents <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/sobb_project.sv
// Offset, projection on the three axes and clamp to the half sizes (three stages).
module sobb_project #(
  parameter int COORD_WIDTH = sobb_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sobb_pkg::cfg_t                        cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0][COORD_WIDTH-1:0]           point,
  input  logic [sobb_pkg::RADIUS_W-1:0]         radius,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0][sobb_pkg::T_W-1:0]         proj,
  output logic [2:0][COORD_WIDTH-1:0]           point_out,
  output logic [sobb_pkg::RSQ_W-1:0]            rsq,
  output logic                                  in_box
);
  import sobb_pkg::*;

  localparam int DW   = ((COORD_WIDTH > LANE_W) ? COORD_WIDTH : LANE_W) + 1;
  localparam int PW   = DW + LANE_W;
  localparam int DOTW = PW + 2;

  logic valid1, valid2, valid3;
  logic rdy1, rdy2, rdy3;

  logic signed [DW-1:0]        d1 [3];
  logic [2:0][COORD_WIDTH-1:0] p1, p2;
  logic [RADIUS_W-1:0]         r1;
  logic signed [PW-1:0]        prod2 [3][3];
  logic [RSQ_W-1:0]            rsq2;

  logic signed [DOTW-1:0] dot [3];
  logic signed [DOTW-1:0] hz  [3];
  logic signed [DOTW-1:0] rnd [3];
  logic signed [T_W-1:0]  hs  [3];
  logic [2:0][T_W-1:0]    proj_next;
  logic [2:0]             outside;
  logic                   inside_next;

  assign rdy3     = !valid3 || out_ready;
  assign rdy2     = !valid2 || rdy3;
  assign rdy1     = !valid1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = valid3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (rdy1) valid1 <= in_valid;
      if (rdy2) valid2 <= valid1;
      if (rdy3) valid3 <= valid2;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot[i] = DOTW'(prod2[i][0]) + DOTW'(prod2[i][1]) + DOTW'(prod2[i][2]);
      hz[i]  = DOTW'($signed({1'b0, half_comp(cfg, i), {AXIS_FRAC{1'b0}}}));
      rnd[i] = (dot[i] + DOTW'(ROUND_HALF)) >>> AXIS_FRAC;
      hs[i]  = $signed({1'b0, half_comp(cfg, i)});
      if (dot[i] > hz[i]) begin
        proj_next[i] = hs[i];
        outside[i]   = 1'b1;
      end else if (dot[i] < -hz[i]) begin
        proj_next[i] = -hs[i];
        outside[i]   = 1'b1;
      end else begin
        proj_next[i] = rnd[i][T_W-1:0];
        outside[i]   = 1'b0;
      end
    end
    inside_next = ~|outside;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int k = 0; k < 3; k++) begin
        d1[k] <= $signed({{(DW-COORD_WIDTH){point[k][COORD_WIDTH-1]}}, point[k]})
               - DW'(center_comp(cfg, k));
      end
      p1 <= point;
      r1 <= radius;
    end
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod2[i][k] <= PW'(d1[k]) * PW'(axis_comp(cfg, i, k));
        end
      end
      p2   <= p1;
      rsq2 <= RSQ_W'(r1) * RSQ_W'(r1);
    end
    if (rdy3) begin
      proj      <= proj_next;
      point_out <= p2;
      rsq       <= rsq2;
      in_box    <= inside_next;
    end
  end

endmodule

>>> rtl/sobb_rebuild.sv
// Sum the clamped projections back along the axes and round the closest point (two stages).
module sobb_rebuild #(
  parameter int COORD_WIDTH = sobb_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sobb_pkg::cfg_t                        cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0][sobb_pkg::T_W-1:0]         proj,
  input  logic [2:0][COORD_WIDTH-1:0]           point,
  input  logic [sobb_pkg::RSQ_W-1:0]            rsq,
  input  logic                                  in_box,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0][sobb_pkg::CL_W-1:0]        closest,
  output logic [2:0][COORD_WIDTH-1:0]           point_out,
  output logic [sobb_pkg::RSQ_W-1:0]            rsq_out,
  output logic                                  inside_out
);
  import sobb_pkg::*;

  logic valid4, valid5;
  logic rdy4, rdy5;

  logic signed [TPW-1:0]       prod4 [3][3];
  logic [2:0][COORD_WIDTH-1:0] p4;
  logic [RSQ_W-1:0]            rsq4;
  logic                        inside4;

  logic signed [QW-1:0]   q  [3];
  logic signed [QW-1:0]   rq [3];
  logic [2:0][CL_W-1:0]   closest_next;

  assign rdy5      = !valid5 || out_ready;
  assign rdy4      = !valid4 || rdy5;
  assign in_ready  = rdy4;
  assign out_valid = valid5;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      valid5 <= 1'b0;
    end else begin
      if (rdy4) valid4 <= in_valid;
      if (rdy5) valid5 <= valid4;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q[k] = QW'($signed({center_comp(cfg, k), {AXIS_FRAC{1'b0}}}))
           + QW'(prod4[0][k]) + QW'(prod4[1][k]) + QW'(prod4[2][k]);
      rq[k] = (q[k] + QW'(ROUND_HALF)) >>> AXIS_FRAC;
      closest_next[k] = rq[k][CL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod4[i][k] <= TPW'($signed(proj[i])) * TPW'(axis_comp(cfg, i, k));
        end
      end
      p4      <= point;
      rsq4    <= rsq;
      inside4 <= in_box;
    end
    if (rdy5) begin
      closest    <= closest_next;
      point_out  <= p4;
      rsq_out    <= rsq4;
      inside_out <= inside4;
    end
  end

endmodule

>>> rtl/sobb_dist.sv
// Squared distance, radius compare and coordinate saturation (two stages).
module sobb_dist #(
  parameter int COORD_WIDTH = sobb_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0][sobb_pkg::CL_W-1:0]        closest,
  input  logic [2:0][COORD_WIDTH-1:0]           point,
  input  logic [sobb_pkg::RSQ_W-1:0]            rsq,
  input  logic                                  in_box,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0][COORD_WIDTH-1:0]           closest_sat,
  output logic [sobb_pkg::DIST_W-1:0]           dist_sq,
  output logic                                  point_inside,
  output logic                                  sphere_hit
);
  import sobb_pkg::*;

  localparam int XW = ((CL_W > COORD_WIDTH) ? CL_W : COORD_WIDTH) + 1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic signed [XW-1:0] COORD_HI =
    XW'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
  localparam logic signed [XW-1:0] COORD_LO =
    XW'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}));

  logic valid6, valid7;
  logic rdy6, rdy7;

  logic signed [XW-1:0]        cle  [3];
  logic signed [XW-1:0]        diff [3];
  logic [XW-1:0]               mag  [3];
  logic [MAG_W-1:0]            magc [3];
  logic [2:0][COORD_WIDTH-1:0] sat_next;

  logic [SQ_W-1:0]             sq6 [3];
  logic [2:0][COORD_WIDTH-1:0] cs6;
  logic [RSQ_W-1:0]            rsq6;
  logic                        inside6;

  logic [SUM_W-1:0]            sum;

  assign rdy7      = !valid7 || out_ready;
  assign rdy6      = !valid6 || rdy7;
  assign in_ready  = rdy6;
  assign out_valid = valid7;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid6 <= 1'b0;
      valid7 <= 1'b0;
    end else begin
      if (rdy6) valid6 <= in_valid;
      if (rdy7) valid7 <= valid6;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cle[k]  = XW'($signed(closest[k]));
      diff[k] = cle[k] - XW'($signed(point[k]));
      mag[k]  = diff[k][XW-1] ? XW'(-diff[k]) : XW'(diff[k]);
      magc[k] = (mag[k] > XW'(DIFF_CLAMP)) ? MAG_W'(DIFF_CLAMP) : mag[k][MAG_W-1:0];
      if (cle[k] > COORD_HI) begin
        sat_next[k] = COORD_HI[COORD_WIDTH-1:0];
      end else if (cle[k] < COORD_LO) begin
        sat_next[k] = COORD_LO[COORD_WIDTH-1:0];
      end else begin
        sat_next[k] = cle[k][COORD_WIDTH-1:0];
      end
    end
    sum = SUM_W'(sq6[0]) + SUM_W'(sq6[1]) + SUM_W'(sq6[2]);
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      for (int k = 0; k < 3; k++) begin
        sq6[k] <= SQ_W'(magc[k]) * SQ_W'(magc[k]);
      end
      cs6     <= sat_next;
      rsq6    <= rsq;
      inside6 <= in_box;
    end
    if (rdy7) begin
      closest_sat  <= cs6;
      dist_sq      <= (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
      point_inside <= inside6;
      sphere_hit   <= sum < SUM_W'(rsq6);
    end
  end

endmodule

>>> rtl/sphere_obb_closest_point_test.sv
// Top level of the sphere to oriented box closest point test.
//
//   channel  direction  handshake             payload
//   s_*      in         s_tvalid / s_tready   point_x, point_y, point_z, sphere_radius
//   m_*      out        m_tvalid / m_tready   closest_x/y/z, dist_sq, point_inside, sphere_hit
//   cfg_*    in         cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while m_tready stays high; the path has seven
// register stages for projection, clamp, rebuild and distance.
// Reset is synchronous: it empties every stage and restores the box registers.
// A stalled stage holds its item; empty stages ahead of it still fill.
module sphere_obb_closest_point_test #(
  parameter int COORD_WIDTH = sobb_pkg::COORD_WIDTH_DEFAULT,
  localparam int IN_DW  = ((3 * COORD_WIDTH + sobb_pkg::RADIUS_W + 7) / 8) * 8,
  localparam int OUT_DW = ((3 * COORD_WIDTH + sobb_pkg::DIST_W + 2 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // point_x, point_y, point_z, sphere_radius, zero fill
  input  logic [IN_DW-1:0]                s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // closest_x, closest_y, closest_z, dist_sq, point_inside, sphere_hit, zero fill
  output logic [OUT_DW-1:0]               m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sobb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sobb_pkg::REG_W-1:0]      cfg_data
);
  import sobb_pkg::*;

  cfg_t box_cfg;

  logic [2:0][COORD_WIDTH-1:0] in_point;
  logic [RADIUS_W-1:0]         in_radius;

  logic                        proj_valid, proj_ready;
  logic [2:0][T_W-1:0]         proj;
  logic [2:0][COORD_WIDTH-1:0] proj_point;
  logic [RSQ_W-1:0]            proj_rsq;
  logic                        proj_inside;

  logic                        rb_valid, rb_ready;
  logic [2:0][CL_W-1:0]        rb_closest;
  logic [2:0][COORD_WIDTH-1:0] rb_point;
  logic [RSQ_W-1:0]            rb_rsq;
  logic                        rb_inside;

  logic [2:0][COORD_WIDTH-1:0] closest_sat;
  logic [DIST_W-1:0]           dist_sq;
  logic                        point_inside;
  logic                        sphere_hit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_point[k] = s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
    end
    in_radius = s_tdata[3*COORD_WIDTH +: RADIUS_W];
  end

  sobb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (box_cfg)
  );

  sobb_project #(.COORD_WIDTH(COORD_WIDTH)) u_project (
    .clk       (clk),
    .rst       (rst),
    .cfg       (box_cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .point     (in_point),
    .radius    (in_radius),
    .out_valid (proj_valid),
    .out_ready (proj_ready),
    .proj      (proj),
    .point_out (proj_point),
    .rsq       (proj_rsq),
    .in_box    (proj_inside)
  );

  sobb_rebuild #(.COORD_WIDTH(COORD_WIDTH)) u_rebuild (
    .clk        (clk),
    .rst        (rst),
    .cfg        (box_cfg),
    .in_valid   (proj_valid),
    .in_ready   (proj_ready),
    .proj       (proj),
    .point      (proj_point),
    .rsq        (proj_rsq),
    .in_box     (proj_inside),
    .out_valid  (rb_valid),
    .out_ready  (rb_ready),
    .closest    (rb_closest),
    .point_out  (rb_point),
    .rsq_out    (rb_rsq),
    .inside_out (rb_inside)
  );

  sobb_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (rb_valid),
    .in_ready     (rb_ready),
    .closest      (rb_closest),
    .point        (rb_point),
    .rsq          (rb_rsq),
    .in_box       (rb_inside),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .closest_sat  (closest_sat),
    .dist_sq      (dist_sq),
    .point_inside (point_inside),
    .sphere_hit   (sphere_hit)
  );

  assign m_tdata = OUT_DW'({sphere_hit, point_inside, dist_sq,
                            closest_sat[2], closest_sat[1], closest_sat[0]});

endmodule

>>> rtl/sobb_checker.sv
// Port-level checker for the sphere to box test, bound to the top level.
`include "sphere_obb_closest_point_test_defines.svh"

module sobb_checker #(
  parameter int COORD_WIDTH = sobb_pkg::COORD_WIDTH_DEFAULT,
  localparam int OUT_DW = ((3 * COORD_WIDTH + sobb_pkg::DIST_W + 2 + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_DW-1:0] m_tdata
);
  import sobb_pkg::*;

  localparam int DIST_LO = 3 * COORD_WIDTH;
  localparam int DIST_HI = DIST_LO + DIST_W - 1;
  localparam int HIT_BIT = DIST_LO + DIST_W + 1;
  localparam logic [DIST_W-1:0] RSQ_LIMIT = DIST_W'(1) << RSQ_W;

  `SOBB_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result item dropped while stalled")
  `SOBB_ASSERT(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata), "result item changed while stalled")
  `SOBB_ASSERT(a_flow, clk, rst, m_tready |-> s_tready, "input held off while output drains")
  `SOBB_ASSERT(a_hit_near, clk, rst, m_tvalid && m_tdata[HIT_BIT] |-> m_tdata[DIST_HI:DIST_LO] < RSQ_LIMIT, "sphere hit with distance beyond any radius")
  `SOBB_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result item present after reset")

endmodule

bind sphere_obb_closest_point_test sobb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
